// File: hdl/adl_pkg.sv
package adl_pkg;

    // Adler-32 modulus: the largest prime below 2**16.
    localparam int unsigned ADL_MOD = 65521;

    // Width of the byte count field and of a weighted lane product.
    localparam int CNT_W  = 4;
    localparam int PROD_W = 8 + CNT_W;

    // Side information that travels down the pipeline with the lane sums.
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] count;
        logic [15:0]      seed_a;
        logic [15:0]      seed_b;
    } adl_ctl_t;

    // One conditional subtraction of the modulus; valid for inputs below 2 * ADL_MOD.
    function automatic logic [15:0] fold16(input logic [16:0] v);
        logic [16:0] d;
        d = v - 17'(ADL_MOD);
        return (v >= 17'(ADL_MOD)) ? d[15:0] : v[15:0];
    endfunction

endpackage

// File: hdl/adl_in_if.sv
interface adl_in_if
#(
    parameter int BYTES_PER_ITEM = 8
);
    logic                        valid;
    logic                        ready;
    logic                        start_req;
    logic [31:0]                 seed;
    logic [8*BYTES_PER_ITEM-1:0] data_bytes;
    logic [3:0]                  byte_count;

    modport source (output valid, start_req, seed, data_bytes, byte_count, input ready);
    modport sink   (input valid, start_req, seed, data_bytes, byte_count, output ready);
endinterface

interface adl_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] checksum;

    modport source (output valid, checksum, input ready);
    modport sink   (input valid, checksum, output ready);
endinterface

// File: hdl/adl_lane.sv
module adl_lane
    import adl_pkg::*;
#(
    parameter int LANE = 0
)
(
    input  logic              clk,
    input  logic              en,
    input  logic [7:0]        byte_in,
    input  logic [CNT_W-1:0]  count,
    output logic [7:0]        plain_reg,
    output logic [PROD_W-1:0] weighted_reg
);

    logic              active;
    logic [CNT_W-1:0]  weight;
    logic [PROD_W-1:0] prod;
    logic [7:0]        plain_next;
    logic [PROD_W-1:0] weighted_next;

    // A byte at position i is added to B once for each of the (count - i) steps it survives.
    always_comb
    begin
        active        = count > CNT_W'(LANE);
        weight        = count - CNT_W'(LANE);
        prod          = PROD_W'(byte_in) * PROD_W'(weight);
        plain_next    = active ? byte_in : 8'd0;
        weighted_next = active ? prod : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            plain_reg    <= plain_next;
            weighted_reg <= weighted_next;
        end
    end

endmodule

// File: hdl/adl_merge.sv
module adl_merge
    import adl_pkg::*;
#(
    parameter int LANES = 8,
    parameter int SA_W  = 11,
    parameter int SB_W  = 14
)
(
    input  logic              clk,
    input  logic              en,
    input  adl_ctl_t          ctl_in,
    input  logic [7:0]        plain    [LANES],
    input  logic [PROD_W-1:0] weighted [LANES],
    output adl_ctl_t          ctl_reg,
    output logic [SA_W-1:0]   sum_a_reg,
    output logic [SB_W-1:0]   sum_b_reg
);

    logic [SA_W-1:0] sum_a_next;
    logic [SB_W-1:0] sum_b_next;

    always_comb
    begin
        sum_a_next = '0;
        sum_b_next = '0;
        for (int i = 0; i < LANES; i++)
        begin
            sum_a_next = sum_a_next + SA_W'(plain[i]);
            sum_b_next = sum_b_next + SB_W'(weighted[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg   <= ctl_in;
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
        end
    end

endmodule

// File: hdl/adler32_checksum_unit.sv
// Channel      Dir   Beat payload
// data_ch      in    start_req, seed[31:0], data_bytes[8*BYTES_PER_ITEM-1:0], byte_count[3:0]
// result_ch    out   checksum[31:0] = {sum B, sum A}
//
// One beat is taken every clock cycle while result_ch is not stalled. A beat's result passes
// through the lane registers and the merge registers into the running sums on result_ch.
// The three stages are: byte lanes, lane merge, and the running-sum update with output register.
// The sum update folds both sums back into range combinationally, before they are registered.
// Reset sets sum A to 1 and sum B to 0 and empties the pipeline.
// A stall on result_ch holds the output; the earlier stages keep filling until all are full.
module adler32_checksum_unit
    import adl_pkg::*;
#(
    parameter int BYTES_PER_ITEM = 8
)
(
    input  logic          clk,
    input  logic          rst_n,
    adl_in_if.sink        data_ch,
    adl_out_if.source     result_ch
);

    // Widths of the lane sums: plain byte sum for A, position-weighted sum for B.
    localparam int SA_W = $clog2(255 * BYTES_PER_ITEM + 1);
    localparam int SB_W = $clog2(255 * BYTES_PER_ITEM * (BYTES_PER_ITEM + 1) / 2 + 1);

    // Pipeline occupancy and stage enables. A stage may load when it is empty
    // or when its contents move on in the same cycle.
    logic v1_reg;
    logic v2_reg;
    logic out_valid_reg;
    logic en1;
    logic en2;
    logic en3;
    logic load1;
    logic load2;
    logic load3;

    assign en3   = !out_valid_reg || result_ch.ready;
    assign en2   = !v2_reg || en3;
    assign en1   = !v1_reg || en2;
    assign load1 = en1 && data_ch.valid;
    assign load2 = en2 && v1_reg;
    assign load3 = en3 && v2_reg;

    assign data_ch.ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= data_ch.valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                out_valid_reg <= v2_reg;
            end
        end
    end

    // Stage 1: the count saturates at the lane count, and the seed halves are
    // brought into range here so the sum update never sees them unreduced.
    logic [CNT_W-1:0] count_sat;
    adl_ctl_t         ctl1_next;
    adl_ctl_t         ctl1_reg;

    always_comb
    begin
        count_sat = (data_ch.byte_count > CNT_W'(BYTES_PER_ITEM))
                    ? CNT_W'(BYTES_PER_ITEM) : data_ch.byte_count;
        ctl1_next.start  = data_ch.start_req;
        ctl1_next.count  = count_sat;
        ctl1_next.seed_a = fold16({1'b0, data_ch.seed[15:0]});
        ctl1_next.seed_b = fold16({1'b0, data_ch.seed[31:16]});
    end

    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            ctl1_reg <= ctl1_next;
        end
    end

    // Each lane handles one byte position and registers its plain and weighted terms.
    logic [7:0]        plain1    [BYTES_PER_ITEM];
    logic [PROD_W-1:0] weighted1 [BYTES_PER_ITEM];

    for (genvar i = 0; i < BYTES_PER_ITEM; i++)
    begin : g_lane
        adl_lane #(
            .LANE(i)
        ) u_lane (
            .clk          (clk),
            .en           (load1),
            .byte_in      (data_ch.data_bytes[8*i +: 8]),
            .count        (count_sat),
            .plain_reg    (plain1[i]),
            .weighted_reg (weighted1[i])
        );
    end

    // Stage 2: the merge adds the lane terms into the item's A and B contributions.
    adl_ctl_t        ctl2_reg;
    logic [SA_W-1:0] sum_a2_reg;
    logic [SB_W-1:0] sum_b2_reg;

    adl_merge #(
        .LANES (BYTES_PER_ITEM),
        .SA_W  (SA_W),
        .SB_W  (SB_W)
    ) u_merge (
        .clk       (clk),
        .en        (load2),
        .ctl_in    (ctl1_reg),
        .plain     (plain1),
        .weighted  (weighted1),
        .ctl_reg   (ctl2_reg),
        .sum_a_reg (sum_a2_reg),
        .sum_b_reg (sum_b2_reg)
    );

    // Stage 3: combine with the running sums.
    //   A' = A0 + sum(d_i)
    //   B' = B0 + n * A0 + sum((n - i) * d_i)
    // A' stays below twice the modulus, so one subtraction suffices. B' is
    // reduced using 2**16 = 15 (mod 65521): the bits above 16 are folded in
    // with weight 15, which leaves a value below twice the modulus.
    logic [15:0] sum_low_reg;
    logic [15:0] sum_high_reg;
    logic [15:0] sum_low_next;
    logic [15:0] sum_high_next;
    logic [15:0] a0;
    logic [15:0] b0;
    logic [19:0] na0;
    logic [19:0] b_raw;
    logic [16:0] b_part;

    always_comb
    begin
        a0            = ctl2_reg.start ? ctl2_reg.seed_a : sum_low_reg;
        b0            = ctl2_reg.start ? ctl2_reg.seed_b : sum_high_reg;
        sum_low_next  = fold16(17'(a0) + 17'(sum_a2_reg));
        na0           = 20'(a0) * 20'(ctl2_reg.count);
        b_raw         = 20'(b0) + na0 + 20'(sum_b2_reg);
        b_part        = 17'(b_raw[15:0]) + 17'(b_raw[19:16]) * 17'd15;
        sum_high_next = fold16(b_part);
    end

    // The running sums double as the output register: they change only when a
    // new result is loaded, which happens only once the previous one is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_low_reg  <= 16'd1;
            sum_high_reg <= 16'd0;
        end
        else if (load3)
        begin
            sum_low_reg  <= sum_low_next;
            sum_high_reg <= sum_high_next;
        end
    end

    assign result_ch.valid    = out_valid_reg;
    assign result_ch.checksum = {sum_high_reg, sum_low_reg};

endmodule

// File: hdl/adl_chk.sv
module adl_chk
    import adl_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] checksum
);

    // A result waiting on a stalled sink stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        $past(out_valid) && !$past(out_ready) |-> out_valid && $stable(checksum))
        else $error("result changed while stalled");

    // Both halves of a delivered checksum are reduced.
    a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (checksum[15:0] < 16'(ADL_MOD)) && (checksum[31:16] < 16'(ADL_MOD)))
        else $error("checksum half not reduced");

    // Input back-pressure only comes from a stalled output.
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output stall");

    // The pipeline keeps at most three items, so after three beats are accepted while the
    // output stays stalled, the input cannot be ready.
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready && $past(out_valid && !out_ready)
        && $past(out_valid && !out_ready, 2) && $past(out_valid && !out_ready, 3)
        && $past(in_valid && in_ready) && $past(in_valid && in_ready, 2)
        && $past(in_valid && in_ready, 3) |-> !in_ready)
        else $error("pipeline accepted beyond its depth");

endmodule

bind adler32_checksum_unit adl_chk u_adl_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (data_ch.valid),
    .in_ready  (data_ch.ready),
    .out_valid (result_ch.valid),
    .out_ready (result_ch.ready),
    .checksum  (result_ch.checksum)
);

// File: dv/testbench.sv
`timescale 1ns / 1ps

// Checks the running Adler-32 engine one beat at a time.
// A scoreboard keeps its own copy of sum A and sum B. It updates them for every data beat
// that the block accepts, and it queues the checksum that this beat must produce.
// Result beats are popped in order and compared against that queue.
// Stimulus comes in two parts. A short directed part covers the reset state, seeds at and
// above the modulus, counts of zero and counts above the lane width, and bytes past the
// count. A random part follows, made mostly of messages that start with a seed and run on
// for a random number of beats. A few messages run on without a start.
// Both channels idle at random, and once the result side holds off long enough that the
// block fills up and stalls its input.
module testbench;

    import adl_pkg::*;

    localparam int          LANES           = 8;
    localparam int unsigned ADLER_BASE      = 65521;
    localparam int          RANDOM_BEATS    = 750;
    localparam int          CALM_BEATS      = 120;
    localparam int          SQUEEZE_AT      = 300;
    localparam int          HOLD_OFF_CYCLES = 80;
    localparam int          DRAIN_CYCLES    = 12;
    localparam int          CYCLE_LIMIT     = 200000;

    // The scoreboard predicts the checksum for each accepted data beat and compares each
    // result beat against the oldest prediction still waiting.
    class adler_scoreboard;
        bit [15:0]   sum_a;
        bit [15:0]   sum_b;
        bit [31:0]   pending_checksums[$];
        int unsigned beats;
        int unsigned starts;
        int unsigned checked;
        int unsigned errors;

        function new();
            sum_a = 16'd1;
            sum_b = 16'd0;
        endfunction

        // The input stays below twice the modulus, so one subtraction brings it back into range.
        function bit [15:0] fold_mod(bit [16:0] v);
            if (v >= 17'(ADLER_BASE))
                v = v - 17'(ADLER_BASE);
            return v[15:0];
        endfunction

        function void note_beat(bit start, bit [31:0] seed, bit [63:0] data, bit [3:0] count);
            int unsigned n;
            beats++;
            if (start)
            begin
                starts++;
                sum_a = fold_mod({1'b0, seed[15:0]});
                sum_b = fold_mod({1'b0, seed[31:16]});
            end
            n = (count > LANES) ? LANES : count;
            for (int i = 0; i < n; i++)
            begin
                sum_a = fold_mod({1'b0, sum_a} + {9'd0, data[8*i +: 8]});
                sum_b = fold_mod({1'b0, sum_b} + {1'b0, sum_a});
            end
            pending_checksums.push_back({sum_b, sum_a});
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= 25)
                $display("ERROR at %0t: %s", $time, msg);
        endtask

        task check_checksum(logic [31:0] got);
            bit [31:0] want;
            if (pending_checksums.size() == 0)
            begin
                report_mismatch($sformatf("checksum %08h arrived with none pending", got));
                return;
            end
            want = pending_checksums.pop_front();
            checked++;
            if (got !== want)
                report_mismatch($sformatf(
                    "checksum %08h, predicted %08h (B %04h/%04h, A %04h/%04h)",
                    got, want, got[31:16], want[31:16], got[15:0], want[15:0]));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    adl_in_if #(.BYTES_PER_ITEM(LANES)) data_ch();
    adl_out_if                          result_ch();

    adler32_checksum_unit #(.BYTES_PER_ITEM(LANES)) DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_ch   (data_ch),
        .result_ch (result_ch)
    );

    adler_scoreboard sb = new();

    int unsigned items_sent  = 0;
    int unsigned last_beat   = 0;
    int unsigned cycle_count = 0;
    bit          calm        = 1'b0;
    bit          squeeze_on  = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Every input of the block starts at a known value. Reset is held low from the start and
    // is then released once, at a rising edge.
    initial
    begin
        rst_n                = 1'b0;
        data_ch.valid        = 1'b0;
        data_ch.start_req    = 1'b0;
        data_ch.seed         = '0;
        data_ch.data_bytes   = '0;
        data_ch.byte_count   = '0;
        result_ch.ready      = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // This is a watchdog on the whole run. The limit covers many times the slowest correct
    // run: each beat waits out a full sender gap and a full receiver stall, on top of the
    // pipeline latency and the single long hold-off.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d checksums still pending.",
                     cycle_count, sb.pending_checksums.size());
            $display("adler32_checksum_unit: mismatch");
            $finish;
        end
    end

    // Result beats are sampled at the rising edge. Every driver uses nonblocking assignments,
    // so valid, ready and the checksum seen here are the values from before the edge.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            sb.check_checksum(result_ch.checksum);
    end

    // The result side usually takes beats at once, but it sometimes drops ready for a burst
    // of random length. Once the sender raises squeeze_on, it holds ready low for a long
    // stretch so that all three stages fill and data_ch.ready falls. In the calm last part
    // of the run, ready stays high.
    initial
    begin : result_side
        int unsigned burst;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (squeeze_on)
            begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                squeeze_on = 1'b0;
                result_ch.ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 14);
                result_ch.ready <= 1'b0;
                repeat (burst) @(posedge clk);
                result_ch.ready <= 1'b1;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // This task offers one data beat and returns at the edge that accepts it. A sender gap,
    // when one is drawn, lowers valid first. Back-to-back beats keep valid high, so valid
    // never gets two assignments in one step.
    task automatic send_beat(input bit start, input bit [31:0] seed,
                             input bit [63:0] data, input bit [3:0] count);
        int unsigned gap;
        gap = 0;
        if (!calm && !squeeze_on && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 14);
        if (gap != 0)
        begin
            data_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        data_ch.valid      <= 1'b1;
        data_ch.start_req  <= start;
        data_ch.seed       <= seed;
        data_ch.data_bytes <= data;
        data_ch.byte_count <= count;
        do
            @(posedge clk);
        while (!data_ch.ready);
        sb.note_beat(start, seed, data, count);
        items_sent++;
        if (last_beat != 0 && items_sent + CALM_BEATS >= last_beat)
            calm = 1'b1;
    endtask

    // Seed halves are sometimes small, sometimes fully random, and sometimes close to or
    // above the modulus, so that the reduction applied at load time is exercised.
    function automatic bit [15:0] pick_seed_half();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(0, 3));
            1:       return 16'($urandom_range(65500, 65535));
            default: return 16'($urandom);
        endcase
    endfunction

    // Data is mostly random. All-ones beats push both sums quickly toward the modulus.
    function automatic bit [63:0] pick_data();
        if ($urandom_range(0, 7) == 0)
            return '1;
        return {$urandom, $urandom};
    endfunction

    // Full beats are the common case. Any count from 0 to 15 also turns up, including
    // counts above the lane width.
    function automatic bit [3:0] pick_count();
        if ($urandom_range(0, 3) == 0)
            return 4'($urandom_range(0, 15));
        return 4'(LANES);
    endfunction

    initial
    begin : stimulus
        bit          squeeze_done;
        bit          start;
        int unsigned run_length;
        squeeze_done = 1'b0;
        @(posedge rst_n);
        @(posedge clk);

        // This is the directed part. It starts from the reset state, sum A = 1 and sum B = 0,
        // with no bytes added. Then one byte is added, and the seven bytes past the count
        // must be ignored.
        send_beat(1'b0, 32'hDEAD_BEEF, {$urandom, $urandom}, 4'd0);
        send_beat(1'b0, 32'h1234_5678, {{7{8'hA5}}, 8'h00}, 4'd1);
        // These seeds include halves at and above the modulus.
        send_beat(1'b1, 32'hFFFF_FFFF, 64'd0, 4'd0);
        send_beat(1'b1, {16'd65521, 16'd65521}, {$urandom, $urandom}, 4'd0);
        send_beat(1'b1, {16'hFFF5, 16'h0003}, 64'h0000_0000_0030_2010, 4'd3);
        // A sum just below the modulus receives full beats of 0xFF, so it wraps on the first byte.
        send_beat(1'b1, {16'd65520, 16'd65520}, '1, 4'd8);
        send_beat(1'b0, 32'd0, '1, 4'd15);
        send_beat(1'b0, 32'hFFFF_FFFF, {$urandom, $urandom}, 4'd9);
        send_beat(1'b1, {16'd65520, 16'd1}, '1, 4'd8);
        send_beat(1'b1, 32'd0, 64'd0, 4'd8);
        send_beat(1'b1, 32'd1, 64'h6867_6665_6463_6261, 4'd8);
        // Then every count from 1 to 8 comes once, with random bytes beyond it.
        for (int c = 1; c <= LANES; c++)
            send_beat(1'b0, {$urandom}, {$urandom, $urandom}, 4'(c));

        // This is the random part. Most of it is messages: a seeded start beat followed by a
        // run of beats. Some runs carry no start, so they continue whatever the sums hold.
        // Seeds on beats without a start are random, and the block must ignore them.
        last_beat = items_sent + RANDOM_BEATS;
        while (items_sent < last_beat)
        begin
            if (!squeeze_done && items_sent >= SQUEEZE_AT)
            begin
                squeeze_on   = 1'b1;
                squeeze_done = 1'b1;
            end
            start = ($urandom_range(0, 9) != 0);
            send_beat(start, {pick_seed_half(), pick_seed_half()}, pick_data(), pick_count());
            run_length = $urandom_range(0, 24);
            for (int k = 0; k < run_length && items_sent < last_beat; k++)
                send_beat(1'b0, $urandom, pick_data(), pick_count());
        end
        data_ch.valid <= 1'b0;

        // The watchdog bounds the drain. After it, a few more cycles give a stray extra
        // result beat the chance to show up.
        while (sb.pending_checksums.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d data beats: %0d seeded starts, counts 0 to 15, seeds up to all ones.",
                 sb.beats, sb.starts);
        $display("Compared %0d checksums, with random idling and one %0d-cycle result hold-off.",
                 sb.checked, HOLD_OFF_CYCLES);
        if (sb.errors == 0)
            $display("adler32_checksum_unit: match");
        else
            $display("adler32_checksum_unit: mismatch");
        $finish;
    end

endmodule
